FILE: src/fmm_pkg.sv
// Shared types, codes and single-precision rounding helpers for the matrix multiply unit.
package fmm_pkg;

  localparam logic [1:0] FUNC_LOAD_A = 2'd0;
  localparam logic [1:0] FUNC_LOAD_B = 2'd1;
  localparam logic [1:0] FUNC_READ   = 2'd2;

  localparam logic [1:0] SP_NONE = 2'd0;
  localparam logic [1:0] SP_NAN  = 2'd1;
  localparam logic [1:0] SP_INF  = 2'd2;
  localparam logic [1:0] SP_ZERO = 2'd3;

  localparam logic [31:0] CANON_NAN = 32'h7FC0_0000;
  localparam int SIZE_W = 7;

  typedef struct packed {
    logic [1:0]         sp;
    logic               sgn;
    logic signed [9:0]  e_pre;
    logic [5:0]         lz;
    logic [47:0]        sig;
  } fmm_stage_t;

  function automatic logic [5:0] fmm_lzc(input logic [47:0] sig);
    logic [5:0] lz;
    lz = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (sig[i]) begin
        lz = 6'(47 - i);
      end
    end
    return lz;
  endfunction

  function automatic logic [31:0] fmm_round(input logic sgn, input logic signed [9:0] e_pre,
                                            input logic [5:0] lz, input logic [47:0] sig);
    logic signed [10:0] eb;
    logic [47:0] q;
    logic [47:0] mask;
    logic [5:0]  rsh;
    logic        st;
    logic        rnd;
    logic [7:0]  ef;
    logic [30:0] mag;
    eb   = 11'(e_pre) - 11'({5'b0, lz});
    st   = 1'b0;
    ef   = 8'd0;
    rsh  = 6'd0;
    mask = 48'd0;
    if (eb >= 11'sd1) begin
      q  = sig << lz;
      ef = eb[7:0];
    end else if (e_pre >= 10'sd1) begin
      q = sig << (e_pre[5:0] - 6'd1);
    end else if (e_pre > -10'sd47) begin
      rsh  = 6'(10'sd1 - e_pre);
      q    = sig >> rsh;
      mask = (48'd1 << rsh) - 48'd1;
      st   = |(sig & mask);
    end else begin
      q  = 48'd0;
      st = |sig;
    end
    st  = st | (|q[22:0]);
    rnd = q[23] & (st | q[24]);
    mag = {ef, q[46:24]} + 31'(rnd);
    if (eb >= 11'sd255) begin
      mag = {8'hFF, 23'd0};
    end
    return {sgn, mag};
  endfunction

  function automatic logic [31:0] fmm_final(input fmm_stage_t s);
    logic [31:0] res;
    case (s.sp)
      SP_NAN:  res = CANON_NAN;
      SP_INF:  res = {s.sgn, 8'hFF, 23'd0};
      SP_ZERO: res = {s.sgn, 31'd0};
      default: res = fmm_round(s.sgn, s.e_pre, s.lz, s.sig);
    endcase
    return res;
  endfunction

endpackage

FILE: src/fp32_matrix_multiply_unit.sv
// Top level: element loads into A and B, dot-product sequencer for product reads.
//
// A load is taken while the unit is idle. A product read of size n walks k = 0..n-1 one step at a
// time: each step is a registered store read, the multiplier and the adder, whose result
// feeds the next step; a read with an index out of range goes straight to its result.
// The store is not cleared: read only elements that were loaded.
module fp32_matrix_multiply_unit
  import fmm_pkg::*;
#(
  parameter int MAX_DIM = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [6:0]  cfg_wr_data,   // matrix_size
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,      // row_index[5:0], col_index[11:6], load_value[43:12]
  input  logic [1:0]  in_tuser,      // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,     // product_value
  output logic [0:0]  out_tuser      // index_error
);

  localparam int DEPTH = MAX_DIM * MAX_DIM;
  localparam int AW    = $clog2(DEPTH);
  localparam int NCAP  = (MAX_DIM > 127) ? 127 : MAX_DIM;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]        state_r;
  logic [SIZE_W-1:0] size_r, n, k_r;
  logic [5:0]        row_r, col_r;
  logic [31:0]       acc_r;
  logic              err_r, rd_vld_r;
  logic              out_vld_r;
  logic [31:0]       out_val_r;
  logic              out_err_r;

  logic [5:0]    in_row, in_col;
  logic          ok, in_xfer;
  logic [AW-1:0] wr_addr, a_rd_addr, b_rd_addr;
  logic [31:0]   a_data, b_data, mul_res, add_res;
  logic          mul_vld, add_vld;

  assign in_row    = in_tdata[5:0];
  assign in_col    = in_tdata[11:6];
  assign n         = (size_r > SIZE_W'(NCAP)) ? SIZE_W'(NCAP) : size_r;
  assign ok        = ({1'b0, in_row} < n) && ({1'b0, in_col} < n);
  assign in_tready = state_r == ST_IDLE;
  assign in_xfer   = in_tvalid && in_tready;

  assign wr_addr   = AW'(in_row) * AW'(MAX_DIM) + AW'(in_col);
  assign a_rd_addr = AW'(row_r) * AW'(MAX_DIM) + AW'(k_r);
  assign b_rd_addr = AW'(k_r) * AW'(MAX_DIM) + AW'(col_r);

  fmm_store #(.DEPTH(DEPTH), .AW(AW)) u_store (
    .clk       (clk),
    .a_we      (in_xfer && ok && (in_tuser == FUNC_LOAD_A)),
    .b_we      (in_xfer && ok && (in_tuser == FUNC_LOAD_B)),
    .wr_addr   (wr_addr),
    .wr_data   (in_tdata[43:12]),
    .a_rd_addr (a_rd_addr),
    .b_rd_addr (b_rd_addr),
    .a_rd_data (a_data),
    .b_rd_data (b_data)
  );

  fmm_fmul u_fmul (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (rd_vld_r),
    .op_a    (a_data),
    .op_b    (b_data),
    .out_vld (mul_vld),
    .out_res (mul_res)
  );

  fmm_fadd u_fadd (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (mul_vld),
    .op_x    (acc_r),
    .op_y    (mul_res),
    .out_vld (add_vld),
    .out_res (add_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= SIZE_W'(64);
    end else if (cfg_wr_en) begin
      size_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      rd_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      rd_vld_r  <= state_r == ST_ISSUE;
      out_vld_r <= (state_r == ST_DONE) || (out_vld_r && !out_tready);
      case (state_r)
        ST_IDLE: begin
          if (in_xfer && (in_tuser == FUNC_READ)) begin
            state_r <= ok ? ST_ISSUE : ST_DONE;
          end
        end
        ST_ISSUE: begin
          state_r <= ST_WAIT;
        end
        ST_WAIT: begin
          if (add_vld) begin
            state_r <= (k_r == n - SIZE_W'(1)) ? ST_DONE : ST_ISSUE;
          end
        end
        ST_DONE: begin
          if (!out_vld_r || out_tready) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      row_r <= in_row;
      col_r <= in_col;
      k_r   <= '0;
      acc_r <= 32'd0;
      err_r <= !ok;
    end
    if ((state_r == ST_WAIT) && add_vld) begin
      acc_r <= add_res;
      k_r   <= k_r + SIZE_W'(1);
    end
    if ((state_r == ST_DONE) && (!out_vld_r || out_tready)) begin
      out_val_r <= acc_r;
      out_err_r <= err_r;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_val_r;
  assign out_tuser  = out_err_r;

`ifndef ASSERT_OFF
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tdata == 32'd0)
    else $error("index error result with nonzero value");

  a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_ISSUE |-> k_r < n)
    else $error("step index beyond size in use");

  a_add_when_wait: assert property (@(posedge clk) disable iff (!rst_n)
    add_vld |-> state_r == ST_WAIT)
    else $error("adder result outside accumulate step");

  a_read_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer && (in_tuser == FUNC_READ) && ok |=> state_r == ST_ISSUE)
    else $error("valid read did not start accumulation");
`endif

endmodule

FILE: src/fmm_store.sv
// Element stores for matrices A and B, one write and one registered read port each.
module fmm_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic          clk,
  input  logic          a_we,
  input  logic          b_we,
  input  logic [AW-1:0] wr_addr,
  input  logic [31:0]   wr_data,
  input  logic [AW-1:0] a_rd_addr,
  input  logic [AW-1:0] b_rd_addr,
  output logic [31:0]   a_rd_data,
  output logic [31:0]   b_rd_data
);

  logic [31:0] mem_a [DEPTH];
  logic [31:0] mem_b [DEPTH];

  always_ff @(posedge clk) begin
    if (a_we) begin
      mem_a[wr_addr] <= wr_data;
    end
    a_rd_data <= mem_a[a_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (b_we) begin
      mem_b[wr_addr] <= wr_data;
    end
    b_rd_data <= mem_b[b_rd_addr];
  end

endmodule

FILE: src/fmm_fmul.sv
// Three-stage single-precision multiplier, round to nearest even.
module fmm_fmul
  import fmm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  logic [31:0] op_a,
  input  logic [31:0] op_b,
  output logic        out_vld,
  output logic [31:0] out_res
);

  logic        v1_r, v2_r, v3_r;
  fmm_stage_t  s1_r, s2_r;
  fmm_stage_t  s1_nxt, s2_nxt;
  logic [31:0] res_r;

  logic [7:0]  ea, eb;
  logic        nan_a, nan_b, inf_a, inf_b, zero_a, zero_b;

  always_comb begin
    ea     = (op_a[30:23] == 8'd0) ? 8'd1 : op_a[30:23];
    eb     = (op_b[30:23] == 8'd0) ? 8'd1 : op_b[30:23];
    nan_a  = (op_a[30:23] == 8'hFF) && (op_a[22:0] != 23'd0);
    nan_b  = (op_b[30:23] == 8'hFF) && (op_b[22:0] != 23'd0);
    inf_a  = (op_a[30:23] == 8'hFF) && (op_a[22:0] == 23'd0);
    inf_b  = (op_b[30:23] == 8'hFF) && (op_b[22:0] == 23'd0);
    zero_a = op_a[30:0] == 31'd0;
    zero_b = op_b[30:0] == 31'd0;
    s1_nxt.sgn   = op_a[31] ^ op_b[31];
    s1_nxt.e_pre = $signed({2'b0, ea}) + $signed({2'b0, eb}) - 10'sd126;
    s1_nxt.lz    = 6'd0;
    s1_nxt.sig   = {24'd0, op_a[30:23] != 8'd0, op_a[22:0]} *
                   {24'd0, op_b[30:23] != 8'd0, op_b[22:0]};
    if (nan_a || nan_b || (inf_a && zero_b) || (zero_a && inf_b)) begin
      s1_nxt.sp = SP_NAN;
    end else if (inf_a || inf_b) begin
      s1_nxt.sp = SP_INF;
    end else if (zero_a || zero_b) begin
      s1_nxt.sp = SP_ZERO;
    end else begin
      s1_nxt.sp = SP_NONE;
    end
  end

  always_comb begin
    s2_nxt    = s1_r;
    s2_nxt.lz = fmm_lzc(s1_r.sig);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_r  <= s1_nxt;
    s2_r  <= s2_nxt;
    res_r <= fmm_final(s2_r);
  end

  assign out_vld = v3_r;
  assign out_res = res_r;

endmodule

FILE: src/fmm_fadd.sv
// Three-stage single-precision adder, round to nearest even.
module fmm_fadd
  import fmm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_vld,
  input  logic [31:0] op_x,
  input  logic [31:0] op_y,
  output logic        out_vld,
  output logic [31:0] out_res
);

  logic        v1_r, v2_r, v3_r;
  fmm_stage_t  s1_r, s2_r;
  fmm_stage_t  s1_nxt, s2_nxt;
  logic        zs_r;
  logic [31:0] res_r;

  logic [31:0] big, sml;
  logic [7:0]  e_big, e_sml, d;
  logic [47:0] sig_big, sig_sml, sig_sh, mask;
  logic        st, nan_x, nan_y, inf_x, inf_y;

  always_comb begin
    if (op_x[30:0] >= op_y[30:0]) begin
      big = op_x;
      sml = op_y;
    end else begin
      big = op_y;
      sml = op_x;
    end
    e_big   = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
    e_sml   = (sml[30:23] == 8'd0) ? 8'd1 : sml[30:23];
    d       = e_big - e_sml;
    sig_big = {1'b0, big[30:23] != 8'd0, big[22:0], 23'd0};
    sig_sml = {1'b0, sml[30:23] != 8'd0, sml[22:0], 23'd0};
    mask    = 48'd0;
    if (d >= 8'd48) begin
      sig_sh = 48'd0;
      st     = |sig_sml;
    end else begin
      sig_sh = sig_sml >> d;
      mask   = (48'd1 << d) - 48'd1;
      st     = |(sig_sml & mask);
    end
    sig_sh = sig_sh | {47'd0, st};
    nan_x  = (op_x[30:23] == 8'hFF) && (op_x[22:0] != 23'd0);
    nan_y  = (op_y[30:23] == 8'hFF) && (op_y[22:0] != 23'd0);
    inf_x  = (op_x[30:23] == 8'hFF) && (op_x[22:0] == 23'd0);
    inf_y  = (op_y[30:23] == 8'hFF) && (op_y[22:0] == 23'd0);
    s1_nxt.lz    = 6'd0;
    s1_nxt.e_pre = $signed({2'b0, e_big}) + 10'sd1;
    s1_nxt.sig   = (op_x[31] ^ op_y[31]) ? sig_big - sig_sh : sig_big + sig_sh;
    s1_nxt.sgn   = big[31];
    if (nan_x || nan_y || (inf_x && inf_y && (op_x[31] != op_y[31]))) begin
      s1_nxt.sp = SP_NAN;
    end else if (inf_x) begin
      s1_nxt.sp  = SP_INF;
      s1_nxt.sgn = op_x[31];
    end else if (inf_y) begin
      s1_nxt.sp  = SP_INF;
      s1_nxt.sgn = op_y[31];
    end else begin
      s1_nxt.sp = SP_NONE;
    end
  end

  always_comb begin
    s2_nxt    = s1_r;
    s2_nxt.lz = fmm_lzc(s1_r.sig);
    if ((s1_r.sp == SP_NONE) && (s1_r.sig == 48'd0)) begin
      s2_nxt.sp  = SP_ZERO;
      s2_nxt.sgn = zs_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_r  <= s1_nxt;
    zs_r  <= op_x[31] & op_y[31];
    s2_r  <= s2_nxt;
    res_r <= fmm_final(s2_r);
  end

  assign out_vld = v3_r;
  assign out_res = res_r;

endmodule

FILE: bench/fp32_matrix_multiply_unit_test.sv
// Self-checking bench for the matrix multiply unit: element loads, product reads, size changes.
module fp32_matrix_multiply_unit_test;
  import fmm_pkg::*;

  localparam logic [1:0] FUNC_NONE = 2'd3;
  localparam int DIM = 64;

  typedef struct {
    logic [31:0] value;
    logic        err;
  } product_t;

  typedef struct {
    logic [1:0]  func;
    int          row;
    int          col;
    logic [31:0] value;
    bit          typed;
    logic [31:0] want_value;
    logic        want_err;
  } stim_row_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [6:0]  cfg_wr_data;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;    // row_index[5:0], col_index[11:6], load_value[43:12]
  logic [1:0]  in_tuser;    // func
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;   // product_value
  logic [0:0]  out_tuser;   // index_error

  logic [31:0] a_mem [DIM*DIM];
  logic [31:0] b_mem [DIM*DIM];
  bit          a_set [DIM*DIM];
  bit          b_set [DIM*DIM];
  int          size_now;
  product_t    product_queue [$];
  int          mismatches;
  int          burst_left;
  int          ready_cycle = 0;

  fp32_matrix_multiply_unit #(.MAX_DIM(DIM)) DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser)
  );

  always #5 clk = ~clk;

  function automatic bit fp_is_nan(logic [31:0] b);
    return (b[30:23] == 8'hFF) && (b[22:0] != 0);
  endfunction

  function automatic bit fp_is_inf(logic [31:0] b);
    return (b[30:23] == 8'hFF) && (b[22:0] == 0);
  endfunction

  function automatic void fp_split(input logic [31:0] b, output logic [23:0] m, output int e);
    if (b[30:23] == 0) begin
      m = {1'b0, b[22:0]};
      e = -149;
    end else begin
      m = {1'b1, b[22:0]};
      e = int'(b[30:23]) - 150;
    end
  endfunction

  // Round mag * 2**e2 to single precision, nearest even, subnormals kept.
  function automatic logic [31:0] fp_round(bit s, logic [79:0] mag, int e2);
    int p, lsb, sh, i;
    logic [79:0] q;
    bit g, st;
    if (mag == 0) return {s, 31'd0};
    p = 0;
    for (i = 0; i < 80; i++) if (mag[i]) p = i;
    lsb = p + e2 - 23;
    if (lsb < -149) lsb = -149;
    sh = lsb - e2;
    if (sh <= 0) begin
      q = mag << (-sh);
      g = 0;
      st = 0;
    end else if (sh > 80) begin
      q = 0;
      g = 0;
      st = 1;
    end else begin
      q = mag >> sh;
      g = mag[sh-1];
      st = |(mag & ((80'd1 << (sh - 1)) - 80'd1));
    end
    if (g && (st || q[0])) q = q + 80'd1;
    if (q[24]) begin
      q = q >> 1;
      lsb++;
    end
    if (lsb + 150 >= 255) return {s, 8'hFF, 23'd0};
    if (q[23]) return {s, 8'(lsb + 150), q[22:0]};
    return {s, 8'd0, q[22:0]};
  endfunction

  function automatic logic [31:0] fp_mul(logic [31:0] a, logic [31:0] b);
    logic [23:0] ma, mb;
    int ea, eb;
    bit s;
    s = a[31] ^ b[31];
    if (fp_is_nan(a) || fp_is_nan(b)) return CANON_NAN;
    if ((fp_is_inf(a) && b[30:0] == 0) || (fp_is_inf(b) && a[30:0] == 0)) return CANON_NAN;
    if (fp_is_inf(a) || fp_is_inf(b)) return {s, 8'hFF, 23'd0};
    fp_split(a, ma, ea);
    fp_split(b, mb, eb);
    return fp_round(s, 80'(ma) * 80'(mb), ea + eb);
  endfunction

  function automatic logic [31:0] fp_add(logic [31:0] a, logic [31:0] b);
    logic [31:0] t;
    logic [23:0] ma, mb;
    int ea, eb, sh, rest;
    logic [79:0] x, y;
    if (fp_is_nan(a) || fp_is_nan(b)) return CANON_NAN;
    if (fp_is_inf(a) && fp_is_inf(b) && a[31] != b[31]) return CANON_NAN;
    if (fp_is_inf(a)) return a;
    if (fp_is_inf(b)) return b;
    if (a[30:0] == 0 && b[30:0] == 0) return {a[31] & b[31], 31'd0};
    if (a[30:23] < b[30:23]) begin
      t = a;
      a = b;
      b = t;
    end
    fp_split(a, ma, ea);
    fp_split(b, mb, eb);
    sh = (ea - eb > 50) ? 50 : ea - eb;
    rest = ea - eb - sh;
    x = 80'(ma) << sh;
    if (rest >= 80) begin
      y = 80'(mb != 0);
    end else begin
      y = 80'(mb) >> rest;
      if ((80'(mb) & ((80'd1 << rest) - 80'd1)) != 0) y[0] = 1'b1;
    end
    if (a[31] == b[31]) return fp_round(a[31], x + y, ea - sh);
    if (x == y) return 32'd0;
    if (x > y) return fp_round(a[31], x - y, ea - sh);
    return fp_round(b[31], y - x, ea - sh);
  endfunction

  function automatic logic [31:0] dot_product(int row, int col);
    logic [31:0] acc;
    int k;
    acc = 32'd0;
    for (k = 0; k < size_now; k++)
      acc = fp_add(acc, fp_mul(a_mem[row*DIM + k], b_mem[k*DIM + col]));
    return fp_is_nan(acc) ? CANON_NAN : acc;
  endfunction

  function automatic logic [31:0] rand_float();
    logic [31:0] v;
    v = $urandom;
    case ($urandom_range(0, 9))
      0: ;
      1: v = {v[31], 31'd0};
      2: v = {v[31], 8'hFF, 23'd0};
      3: v = {v[31], 8'hFF, 1'b1, v[21:0]};
      4: v = {v[31], 8'd0, v[22:0]};
      5: v = {v[31], 8'hFE, 23'h7FFFFF};
      default: v = {v[31], 8'($urandom_range(100, 154)), v[22:0]};
    endcase
    return v;
  endfunction

  // Drive one transfer, predict on acceptance, then maybe open a gap.
  task automatic send(logic [1:0] func, int row, int col, logic [31:0] value,
                      bit typed = 0, logic [31:0] want_value = 0, logic want_err = 0);
    product_t p;
    bit ok;
    in_tuser  <= func;
    in_tdata  <= {4'd0, value, 6'(col), 6'(row)};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    ok = (row < size_now) && (col < size_now);
    if (func == FUNC_LOAD_A && ok) begin
      a_mem[row*DIM + col] = value;
      a_set[row*DIM + col] = 1;
    end else if (func == FUNC_LOAD_B && ok) begin
      b_mem[row*DIM + col] = value;
      b_set[row*DIM + col] = 1;
    end else if (func == FUNC_READ) begin
      p.value = ok ? dot_product(row, col) : 32'd0;
      p.err   = !ok;
      if (typed) begin
        p.value = want_value;
        p.err   = want_err;
      end
      product_queue.push_back(p);
    end
    burst_left--;
    if (burst_left <= 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 8);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    while (product_queue.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_size(int raw);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= 7'(raw);
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    size_now = (raw > DIM) ? DIM : raw;
  endtask

  task automatic read_loaded(int row, int col);
    int k;
    for (k = 0; k < size_now; k++) begin
      if (!a_set[row*DIM + k]) send(FUNC_LOAD_A, row, k, rand_float());
      if (!b_set[k*DIM + col]) send(FUNC_LOAD_B, k, col, rand_float());
    end
    send(FUNC_READ, row, col, $urandom);
  endtask

  task automatic random_phase(int raw, int count);
    int i, r, c;
    set_size(raw);
    for (i = 0; i < count; i++) begin
      r = $urandom_range(0, DIM - 1);
      c = $urandom_range(0, DIM - 1);
      if (size_now > 0 && $urandom_range(0, 9) < 8) begin
        r = $urandom_range(0, size_now - 1);
        c = $urandom_range(0, size_now - 1);
      end
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6: send(FUNC_LOAD_A, r, c, rand_float());
        7, 8, 9, 10, 11, 12: send(FUNC_LOAD_B, r, c, rand_float());
        13: send(FUNC_NONE, r, c, $urandom);
        default: begin
          if (r < size_now && c < size_now) read_loaded(r, c);
          else send(FUNC_READ, r, c, $urandom);
        end
      endcase
    end
    drain();
  endtask

  stim_row_t directed [] = '{
    '{FUNC_LOAD_A, 0, 0, 32'h3F800000, 0, 0, 0},
    '{FUNC_LOAD_A, 0, 1, 32'h7F7FFFFF, 0, 0, 0},
    '{FUNC_LOAD_A, 1, 0, 32'h00000001, 0, 0, 0},
    '{FUNC_LOAD_A, 1, 1, 32'h80000000, 0, 0, 0},
    '{FUNC_LOAD_B, 0, 0, 32'h40000000, 0, 0, 0},
    '{FUNC_LOAD_B, 0, 1, 32'h7F800000, 0, 0, 0},
    '{FUNC_LOAD_B, 1, 0, 32'hBF800000, 0, 0, 0},
    '{FUNC_LOAD_B, 1, 1, 32'h7FC00001, 0, 0, 0},
    '{FUNC_READ,   0, 0, 32'hFFFFFFFF, 0, 0, 0},
    '{FUNC_READ,   0, 1, 32'h00000000, 1, CANON_NAN, 0},
    '{FUNC_READ,   1, 0, 32'h00000000, 0, 0, 0},
    '{FUNC_READ,   1, 1, 32'h00000000, 1, CANON_NAN, 0},
    '{FUNC_READ,   2, 0, 32'h00000000, 1, 32'd0, 1},
    '{FUNC_READ,   0, 63, 32'h00000000, 1, 32'd0, 1},
    '{FUNC_READ,   63, 63, 32'h00000000, 1, 32'd0, 1},
    '{FUNC_LOAD_A, 5, 0, 32'h12345678, 0, 0, 0},
    '{FUNC_LOAD_B, 0, 63, 32'hFFFFFFFF, 0, 0, 0},
    '{FUNC_NONE,   0, 0, 32'hDEADBEEF, 0, 0, 0},
    '{FUNC_LOAD_A, 0, 0, 32'h7F7FFFFF, 0, 0, 0},
    '{FUNC_READ,   0, 0, 32'h00000000, 0, 0, 0},
    '{FUNC_LOAD_A, 0, 0, 32'h00800000, 0, 0, 0},
    '{FUNC_LOAD_B, 0, 0, 32'h3F000000, 0, 0, 0},
    '{FUNC_READ,   0, 0, 32'h00000000, 0, 0, 0},
    '{FUNC_READ,   1, 0, 32'h00000000, 0, 0, 0}
  };

  always @(posedge clk) begin
    ready_cycle <= ready_cycle + 1;
    case (ready_cycle[9:8])
      2'd0: out_tready <= 1'b1;
      2'd1: out_tready <= 1'($urandom_range(0, 1));
      2'd2: out_tready <= (ready_cycle[2:0] == 3'd0);
      default: out_tready <= ($urandom_range(0, 7) != 0);
    endcase
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (product_queue.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h err %b", out_tdata, out_tuser);
      end else begin
        if (out_tdata !== product_queue[0].value || out_tuser[0] !== product_queue[0].err) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected %h err %b, got %h err %b", product_queue[0].value,
                     product_queue[0].err, out_tdata, out_tuser);
        end
        void'(product_queue.pop_front());
      end
    end
  end

  initial begin
    #50_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int i;
    clk         = 1'b0;
    rst_n       = 1'b0;
    cfg_wr_en   = 1'b0;
    cfg_wr_data = 7'd0;
    in_tvalid   = 1'b0;
    in_tdata    = 48'd0;
    in_tuser    = FUNC_LOAD_A;
    mismatches  = 0;
    burst_left  = 4;
    size_now    = DIM;
    for (i = 0; i < DIM*DIM; i++) begin
      a_set[i] = 0;
      b_set[i] = 0;
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset size: out-of-range cannot happen, so probe func 3 and a full-size read
    send(FUNC_NONE, 63, 63, 32'hFFFFFFFF);
    read_loaded(63, 0);
    drain();

    set_size(2);
    foreach (directed[j])
      send(directed[j].func, directed[j].row, directed[j].col, directed[j].value,
           directed[j].typed, directed[j].want_value, directed[j].want_err);
    drain();

    random_phase(1, 80);
    random_phase(0, 40);
    random_phase(3, 120);
    random_phase(127, 8);
    random_phase(5, 140);
    random_phase(8, 140);
    random_phase(2, 100);
    random_phase(64, 6);
    random_phase(4, 140);
    random_phase(6, 100);

    drain();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && product_queue.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
